// ----- rtl/keypad_combination_lock_macros.svh -----
// ----------------------------------------------------------------------------
// Keypad combination lock assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_COMBINATION_LOCK_MACROS_SVH
`define KEYPAD_COMBINATION_LOCK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define KCL_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad lock assertion failed");

// Next-cycle implication
`define KCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad lock assertion failed");

`else

`define KCL_ASSERT(label, ante, cons)
`define KCL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad combination lock package
// Field widths, key codes and code-store sizes shared by the lock RTL.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Payload widths
    localparam int KEY_W     = 8;
    localparam int PHASE_W   = 3;
    localparam int COUNT_W   = 3;
    localparam int PROG_W    = 2;

    // Code store: full default code and the length of a reprogrammed code
    localparam int CODE_DIGITS     = 5;
    localparam int NEW_CODE_DIGITS = 4;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;
    localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
    localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;

    // Reset code '1' through '5' and the sequence length it implies ('#' + 5)
    localparam logic [KEY_W-1:0]   KEY_DIGIT_ONE   = 8'h31;
    localparam logic [COUNT_W-1:0] SEQ_LEN_DEFAULT = 3'd6;

endpackage

// ----- rtl/kcl_if.sv -----
// ----------------------------------------------------------------------------
// Keypad combination lock channel interfaces
// Valid/ready channels for the polling tick input and the status result.
// ----------------------------------------------------------------------------

// Polling tick channel
interface kcl_tick_if
    import kcl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_code;
    logic               lock_button;

    modport source (output valid, output key_code, output lock_button, input ready);
    modport sink   (input valid, input key_code, input lock_button, output ready);
endinterface

// Status result channel
interface kcl_status_if
    import kcl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               unlocked;
    logic [PHASE_W-1:0] entry_phase;
    logic [COUNT_W-1:0] digits_matched;
    logic [PROG_W-1:0]  program_phase;

    modport source (output valid, output unlocked, output entry_phase,
                    output digits_matched, output program_phase, input ready);
    modport sink   (input valid, input unlocked, input entry_phase,
                    input digits_matched, input program_phase, output ready);
endinterface

// ----- rtl/keypad_combination_lock.sv -----
// ----------------------------------------------------------------------------
// Keypad combination lock
// Unlock and code-change state machines driven by one keypad polling tick
// per transfer, with a registered status result for every tick.
// ----------------------------------------------------------------------------
// Every tick transfer produces exactly one status transfer, presented on the
// clock after the tick is taken. Both state machines update together on each
// tick, and the machine state registers are the result register, so one
// tick is taken every clock: the input is ready whenever the result slot is
// empty or being taken in the same cycle. A stalled status output holds its
// value and stops further ticks until it is taken. After reset the code is
// '1' to '5', entered after '#'; '*' with the lock button held captures a
// new four-digit code.

`include "keypad_combination_lock_macros.svh"

module keypad_combination_lock
    import kcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    kcl_tick_if.sink            key_in,
    kcl_status_if.source        status_out
);

    typedef enum logic [PHASE_W-1:0] {
        EP_START   = 3'd0,
        EP_IDLE    = 3'd1,
        EP_DIGIT   = 3'd2,
        EP_RELEASE = 3'd3,
        EP_OPEN    = 3'd4,
        EP_LOCKING = 3'd5
    } entry_phase_t;

    typedef enum logic [PROG_W-1:0] {
        PP_START   = 2'd0,
        PP_IDLE    = 2'd1,
        PP_RELEASE = 2'd2,
        PP_CAPTURE = 2'd3
    } program_phase_t;

    localparam logic [COUNT_W-1:0] NEW_CODE_CNT  = COUNT_W'(NEW_CODE_DIGITS);
    localparam logic [COUNT_W-1:0] SEQ_LEN_SHORT = COUNT_W'(NEW_CODE_DIGITS + 1);

    entry_phase_t       entry_reg,   entry_next;
    program_phase_t     prog_reg,    prog_next;
    logic [COUNT_W-1:0] match_reg,   match_next;
    logic [COUNT_W-1:0] seq_len_reg, seq_len_next;
    logic [COUNT_W-1:0] capt_cnt_reg, capt_cnt_next;
    logic               open_reg,    open_next;
    logic               out_valid_reg;
    logic [KEY_W-1:0]   code_reg [CODE_DIGITS];
    logic [KEY_W-1:0]   code_next [CODE_DIGITS];
    logic [KEY_W-1:0]   capt_buf_reg [NEW_CODE_DIGITS];
    logic [KEY_W-1:0]   capt_buf_next [NEW_CODE_DIGITS];

    logic               tick_xfer;
    logic [KEY_W-1:0]   key;
    logic               button;
    logic [COUNT_W-1:0] match_inc;
    logic [KEY_W-1:0]   expected_key;
    logic               index_ok;
    logic               digit_hit;

    // Handshake: take a tick whenever the result slot frees up
    assign key_in.ready = !out_valid_reg || status_out.ready;
    assign tick_xfer    = key_in.valid && key_in.ready;
    assign key          = key_in.key_code;
    assign button       = key_in.lock_button;

    // Result fields are the machine state after the tick
    assign status_out.valid          = out_valid_reg;
    assign status_out.unlocked       = open_reg;
    assign status_out.entry_phase    = entry_reg;
    assign status_out.digits_matched = match_reg;
    assign status_out.program_phase  = prog_reg;

    // Expected digit for the current match position ('#' is position 0)
    always_comb
    begin
        expected_key = KEY_NONE;
        index_ok     = 1'b1;
        case (match_reg)
            3'd1:    expected_key = code_reg[0];
            3'd2:    expected_key = code_reg[1];
            3'd3:    expected_key = code_reg[2];
            3'd4:    expected_key = code_reg[3];
            3'd5:    expected_key = code_reg[4];
            default: index_ok     = 1'b0;
        endcase
    end

    assign match_inc = match_reg + 3'd1;
    assign digit_hit = index_ok && (key == expected_key);

    // Next state: unlock machine first, then the code change machine
    always_comb
    begin
        entry_next    = entry_reg;
        match_next    = match_reg;
        open_next     = open_reg;
        prog_next     = prog_reg;
        capt_cnt_next = capt_cnt_reg;
        seq_len_next  = seq_len_reg;
        code_next     = code_reg;
        capt_buf_next = capt_buf_reg;

        // unlock machine
        case (entry_reg)
            EP_START:
                entry_next = EP_IDLE;
            EP_IDLE:
            begin
                if (key == KEY_HASH)
                begin
                    entry_next = EP_DIGIT;
                    match_next = match_inc;
                end
                else if (button)
                begin
                    entry_next = EP_LOCKING;
                end
            end
            EP_DIGIT:
            begin
                if (digit_hit)
                begin
                    match_next = match_inc;
                    entry_next = (match_inc >= seq_len_reg) ? EP_OPEN : EP_RELEASE;
                end
                else if (key == KEY_NONE)
                begin
                    entry_next = EP_DIGIT;
                end
                else if (button)
                begin
                    entry_next = EP_LOCKING;
                end
                else
                begin
                    entry_next = EP_IDLE;
                    match_next = '0;
                end
            end
            EP_RELEASE:
            begin
                if (key == KEY_NONE)
                    entry_next = EP_DIGIT;
            end
            EP_OPEN:
            begin
                if (button)
                    entry_next = EP_LOCKING;
            end
            EP_LOCKING:
            begin
                match_next = '0;
                entry_next = EP_IDLE;
            end
            default:
                entry_next = entry_reg;
        endcase

        // door release follows the phase just entered
        if (entry_next == EP_OPEN)
            open_next = 1'b1;
        else if (entry_next == EP_LOCKING)
            open_next = 1'b0;

        // code change machine
        case (prog_reg)
            PP_START:
                prog_next = PP_IDLE;
            PP_IDLE:
            begin
                if ((key == KEY_STAR) && button)
                begin
                    prog_next     = PP_RELEASE;
                    capt_cnt_next = '0;
                end
            end
            PP_CAPTURE:
            begin
                if (capt_cnt_reg >= NEW_CODE_CNT)
                    prog_next = PP_IDLE;
            end
            PP_RELEASE:
            begin
                if (key == KEY_NONE)
                    prog_next = PP_CAPTURE;
            end
            default:
                prog_next = prog_reg;
        endcase

        // capture one digit per key press
        if ((prog_next == PP_CAPTURE) && (key != KEY_NONE) && (capt_cnt_next < NEW_CODE_CNT))
        begin
            for (int i = 0; i < NEW_CODE_DIGITS; i++)
            begin
                if (capt_cnt_next == COUNT_W'(i))
                    capt_buf_next[i] = key;
            end
            capt_cnt_next = capt_cnt_next + 3'd1;
            prog_next     = PP_RELEASE;
        end

        // full capture replaces the leading digits and shortens the sequence
        if (capt_cnt_next == NEW_CODE_CNT)
        begin
            for (int i = 0; i < NEW_CODE_DIGITS; i++)
                code_next[i] = capt_buf_next[i];
            seq_len_next = SEQ_LEN_SHORT;
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg     <= EP_START;
            prog_reg      <= PP_START;
            match_reg     <= '0;
            seq_len_reg   <= SEQ_LEN_DEFAULT;
            capt_cnt_reg  <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CODE_DIGITS; i++)
                code_reg[i] <= KEY_DIGIT_ONE + KEY_W'(i);
        end
        else
        begin
            if (tick_xfer)
            begin
                entry_reg    <= entry_next;
                prog_reg     <= prog_next;
                match_reg    <= match_next;
                seq_len_reg  <= seq_len_next;
                capt_cnt_reg <= capt_cnt_next;
                open_reg     <= open_next;
                code_reg     <= code_next;
            end
            if (tick_xfer)
                out_valid_reg <= 1'b1;
            else if (status_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture buffer, payload only
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
            capt_buf_reg <= capt_buf_next;
    end

    // Assertions
    `KCL_ASSERT(a_open_tracks_phase, 1'b1, open_reg == (entry_reg == EP_OPEN))
    `KCL_ASSERT(a_idle_no_match, entry_reg == EP_IDLE, match_reg == '0)
    `KCL_ASSERT(a_capture_bound, 1'b1, capt_cnt_reg <= NEW_CODE_CNT)
    `KCL_ASSERT(a_seq_len_legal, 1'b1,
                (seq_len_reg == SEQ_LEN_DEFAULT) || (seq_len_reg == SEQ_LEN_SHORT))
    `KCL_ASSERT_NEXT(a_tick_gives_result, tick_xfer, out_valid_reg)

endmodule

// ----- tb/keypad_combination_lock_test.sv -----
// ----------------------------------------------------------------------------
// Keypad combination lock regression
// Drives polling ticks into the lock, predicts every status transfer with a
// cycle-free model of both state machines, and compares each one field by
// field. Runs unlock attempts, code changes, locks and noise under several
// idle and stall mixes, including one long output hold-off.
// ----------------------------------------------------------------------------
module keypad_combination_lock_test;
    import kcl_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_TICKS   = 1150;
    localparam int PHASES         = 4;

    localparam logic [KEY_W-1:0] KEY_ALL_ONES = 8'hFF;
    localparam logic [KEY_W-1:0] KEY_DIGIT_ZERO = 8'h30;

    typedef enum logic [PHASE_W-1:0] {
        ENTRY_START,
        ENTRY_IDLE,
        ENTRY_DIGIT,
        ENTRY_RELEASE,
        ENTRY_OPEN,
        ENTRY_LOCKING
    } entry_phase_t;

    typedef enum logic [PROG_W-1:0] {
        PROG_START,
        PROG_IDLE,
        PROG_RELEASE,
        PROG_CAPTURE
    } program_phase_t;

    typedef struct packed {
        logic               unlocked;
        logic [PHASE_W-1:0] entry_phase;
        logic [COUNT_W-1:0] digits_matched;
        logic [PROG_W-1:0]  program_phase;
    } lock_status_t;

    // Lock state tracker and queue of status values still owed by the block
    class lock_scoreboard;
        entry_phase_t       entry_state   = ENTRY_START;
        logic [COUNT_W-1:0] matched_keys  = '0;
        logic [KEY_W-1:0]   lock_code [CODE_DIGITS];
        logic [COUNT_W-1:0] seq_len       = SEQ_LEN_DEFAULT;
        logic               open_flag     = 1'b0;
        program_phase_t     prog_state    = PROG_START;
        logic [KEY_W-1:0]   capture_store [NEW_CODE_DIGITS];
        logic [COUNT_W-1:0] capture_count = '0;
        lock_status_t       owed_status [$];
        int                 errors        = 0;

        function new();
            for (int i = 0; i < CODE_DIGITS; i++)
                lock_code[i] = KEY_DIGIT_ONE + KEY_W'(i);
            for (int i = 0; i < NEW_CODE_DIGITS; i++)
                capture_store[i] = KEY_NONE;
        endfunction

        // Advance both machines by one accepted tick and queue the status
        function void note_tick(input logic [KEY_W-1:0] key, input logic button);
            logic         hit;
            lock_status_t next_status;

            // Unlock machine
            case (entry_state)
                ENTRY_START:
                    entry_state = ENTRY_IDLE;
                ENTRY_IDLE:
                begin
                    if (key == KEY_HASH)
                    begin
                        entry_state  = ENTRY_DIGIT;
                        matched_keys = matched_keys + 1'b1;
                    end
                    else if (button)
                        entry_state = ENTRY_LOCKING;
                end
                ENTRY_DIGIT:
                begin
                    // an index outside the code never matches
                    hit = (matched_keys >= 1 && matched_keys <= CODE_DIGITS)
                          && (key == lock_code[matched_keys - 1'b1]);
                    if (hit)
                    begin
                        matched_keys = matched_keys + 1'b1;
                        if (matched_keys >= seq_len)
                            entry_state = ENTRY_OPEN;
                        else
                            entry_state = ENTRY_RELEASE;
                    end
                    else if (key == KEY_NONE)
                    begin
                        // still waiting for a key
                    end
                    else if (button)
                        entry_state = ENTRY_LOCKING;
                    else
                    begin
                        entry_state  = ENTRY_IDLE;
                        matched_keys = '0;
                    end
                end
                ENTRY_RELEASE:
                begin
                    if (key == KEY_NONE)
                        entry_state = ENTRY_DIGIT;
                end
                ENTRY_OPEN:
                begin
                    if (button)
                        entry_state = ENTRY_LOCKING;
                end
                ENTRY_LOCKING:
                begin
                    matched_keys = '0;
                    entry_state  = ENTRY_IDLE;
                end
                default:
                begin
                end
            endcase
            if (entry_state == ENTRY_OPEN)
                open_flag = 1'b1;
            else if (entry_state == ENTRY_LOCKING)
                open_flag = 1'b0;

            // Code change machine
            case (prog_state)
                PROG_START:
                    prog_state = PROG_IDLE;
                PROG_IDLE:
                begin
                    if (key == KEY_STAR && button)
                    begin
                        prog_state    = PROG_RELEASE;
                        capture_count = '0;
                    end
                end
                PROG_CAPTURE:
                begin
                    if (capture_count >= NEW_CODE_DIGITS)
                        prog_state = PROG_IDLE;
                end
                PROG_RELEASE:
                begin
                    if (key == KEY_NONE)
                        prog_state = PROG_CAPTURE;
                end
                default:
                begin
                end
            endcase
            if (prog_state == PROG_CAPTURE && key != KEY_NONE
                && capture_count < NEW_CODE_DIGITS)
            begin
                capture_store[capture_count] = key;
                capture_count = capture_count + 1'b1;
                prog_state    = PROG_RELEASE;
            end
            // full capture overwrites the leading digits and shortens the code
            if (capture_count == NEW_CODE_DIGITS)
            begin
                for (int i = 0; i < NEW_CODE_DIGITS; i++)
                    lock_code[i] = capture_store[i];
                seq_len = COUNT_W'(NEW_CODE_DIGITS + 1);
            end

            next_status.unlocked       = open_flag;
            next_status.entry_phase    = entry_state;
            next_status.digits_matched = matched_keys;
            next_status.program_phase  = prog_state;
            owed_status.push_back(next_status);
        endfunction

        // Compare one status transfer against the oldest owed value
        function void check_status(input logic unlocked,
                                   input logic [PHASE_W-1:0] entry_phase,
                                   input logic [COUNT_W-1:0] digits_matched,
                                   input logic [PROG_W-1:0] program_phase);
            lock_status_t want;

            if (owed_status.size() == 0)
            begin
                $error("status transfer with no tick outstanding");
                errors++;
                return;
            end
            want = owed_status.pop_front();
            if (unlocked !== want.unlocked)
            begin
                $error("unlocked: expected %0d, got %0d", want.unlocked, unlocked);
                errors++;
            end
            if (entry_phase !== want.entry_phase)
            begin
                $error("entry_phase: expected %0d, got %0d", want.entry_phase, entry_phase);
                errors++;
            end
            if (digits_matched !== want.digits_matched)
            begin
                $error("digits_matched: expected %0d, got %0d",
                       want.digits_matched, digits_matched);
                errors++;
            end
            if (program_phase !== want.program_phase)
            begin
                $error("program_phase: expected %0d, got %0d",
                       want.program_phase, program_phase);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    kcl_tick_if   key_in ();
    kcl_status_if status_out ();

    keypad_combination_lock u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .status_out (status_out)
    );

    lock_scoreboard lock_sb;
    int ticks_sent         = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int results_seen       = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;
    int max_hold           = 1;
    int max_release        = 1;

    always #HALF_PERIOD clk = ~clk;

    // Offer one tick, with an optional idle gap first; returns on transfer
    task automatic send_tick(input logic [KEY_W-1:0] key, input logic button);
        if (sender_idle_pct > 0 && $urandom_range(1, 100) <= sender_idle_pct)
        begin
            key_in.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(1, 100) <= sender_idle_pct);
        end
        key_in.valid       <= 1'b1;
        key_in.key_code    <= key;
        key_in.lock_button <= button;
        do
            @(posedge clk);
        while (!key_in.ready);
        lock_sb.note_tick(key, button);
        ticks_sent++;
    endtask

    // Press a key for one or more ticks, then release it
    task automatic tap(input logic [KEY_W-1:0] key, input logic button, input logic single);
        int holds;

        holds = single ? 1 : int'($urandom_range(1, max_hold));
        repeat (holds)
            send_tick(key, button);
        repeat ($urandom_range(1, max_release))
            send_tick(KEY_NONE, 1'b0);
    endtask

    function automatic logic [KEY_W-1:0] pick_digit();
        if ($urandom_range(0, 7) == 0)
            return KEY_ALL_ONES - KEY_W'($urandom_range(0, 254));
        return KEY_DIGIT_ZERO + KEY_W'($urandom_range(0, 9));
    endfunction

    // Bring the unlock machine back to idle
    task automatic settle_entry();
        int tries;

        tries = 0;
        while (lock_sb.entry_state != ENTRY_IDLE && tries < 8)
        begin
            if (lock_sb.entry_state == ENTRY_DIGIT || lock_sb.entry_state == ENTRY_OPEN)
                send_tick(KEY_ALL_ONES, 1'b1);
            else
                send_tick(KEY_NONE, 1'b0);
            tries++;
        end
    endtask

    // Finish any capture in progress
    task automatic settle_program();
        int tries;

        tries = 0;
        while (lock_sb.prog_state != PROG_IDLE && tries < 16)
        begin
            if (lock_sb.prog_state == PROG_CAPTURE)
                send_tick(pick_digit(), 1'b0);
            else
                send_tick(KEY_NONE, 1'b0);
            tries++;
        end
    endtask

    // '#' then the stored digits; a wrong attempt breaks off at a random digit
    task automatic try_unlock(input logic correct);
        int               digits;
        int               wrong_at;
        logic [KEY_W-1:0] wrong_key;

        settle_entry();
        if (lock_sb.entry_state != ENTRY_IDLE)
            return;
        digits   = lock_sb.seq_len - 1;
        wrong_at = correct ? -1 : int'($urandom_range(0, digits - 1));
        tap(KEY_HASH, 1'b0, 1'b1);
        for (int i = 0; i < digits; i++)
        begin
            if (i == wrong_at)
            begin
                do
                    wrong_key = KEY_W'($urandom_range(1, 255));
                while (wrong_key == lock_sb.lock_code[i]);
                tap(wrong_key, 1'($urandom_range(0, 1)), 1'b1);
                return;
            end
            tap(lock_sb.lock_code[i], 1'b0, 1'b0);
        end
    endtask

    // Button with '*' then four new digits. With a leading '#' the capture
    // doubles as an entry in progress, so the code shrinks under it and the
    // entry completes against the new code.
    task automatic program_code(input logic hash_first);
        logic [KEY_W-1:0] new_digits [NEW_CODE_DIGITS];

        settle_program();
        if (hash_first)
        begin
            settle_entry();
            new_digits[0] = KEY_HASH;
            for (int i = 1; i < NEW_CODE_DIGITS; i++)
                new_digits[i] = lock_sb.lock_code[i - 1];
        end
        else
        begin
            for (int i = 0; i < NEW_CODE_DIGITS; i++)
                new_digits[i] = pick_digit();
        end
        tap(KEY_STAR, 1'b1, 1'b0);
        for (int i = 0; i < NEW_CODE_DIGITS; i++)
            tap(new_digits[i], 1'b0, hash_first && i == 0);
        if (hash_first)
            tap(lock_sb.lock_code[NEW_CODE_DIGITS - 1], 1'b0, 1'b0);
        else
            send_tick(KEY_NONE, 1'b0);
    endtask

    // One randomly chosen key sequence
    task automatic random_sequence();
        int pick;
        int partial;

        pick = int'($urandom_range(0, 99));
        if (pick < 40)
            try_unlock($urandom_range(0, 3) != 0);
        else if (pick < 55)
            program_code($urandom_range(0, 3) == 0);
        else if (pick < 65)
        begin
            send_tick(KEY_W'($urandom_range(0, 255)), 1'b1);
            send_tick(KEY_NONE, 1'b0);
        end
        else if (pick < 85)
        begin
            repeat ($urandom_range(1, 4))
                send_tick(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            // entry abandoned part way, then locked, hit with noise or met by a code change
            settle_entry();
            tap(KEY_HASH, 1'b0, 1'b1);
            partial = int'($urandom_range(0, 3));
            for (int i = 0; i < partial; i++)
                tap(lock_sb.lock_code[i], 1'b0, 1'b0);
            case ($urandom_range(0, 2))
                0: send_tick(KEY_W'($urandom_range(1, 255)), 1'b1);
                1: send_tick(KEY_W'($urandom_range(0, 255)), 1'b0);
                default: program_code(1'b0);
            endcase
        end
    endtask

    // Status sink: check every transfer, stall at random, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            status_out.ready <= 1'b0;
        else
        begin
            if (status_out.valid && status_out.ready)
            begin
                lock_sb.check_status(status_out.unlocked, status_out.entry_phase,
                                     status_out.digits_matched, status_out.program_phase);
                results_seen++;
                if (results_seen == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                status_out.ready <= 1'b0;
            end
            else
                status_out.ready <= ($urandom_range(1, 100) > receiver_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (key_in.valid && key_in.ready)
                || (status_out.valid && status_out.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial
    begin
        lock_sb            = new();
        rst_n              = 1'b0;
        key_in.valid       = 1'b0;
        key_in.key_code    = KEY_NONE;
        key_in.lock_button = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset code, lock with all-ones key, code shrunk mid-entry
        try_unlock(1'b1);
        send_tick(KEY_ALL_ONES, 1'b1);
        send_tick(KEY_NONE, 1'b0);
        program_code(1'b1);

        // Random sequences under each idle and stall mix
        max_hold    = 3;
        max_release = 2;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 80;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 80;
                end
                default:
                begin
                    sender_idle_pct    = 21;
                    receiver_stall_pct = 21;
                end
            endcase
            while (ticks_sent < RANDOM_TICKS * (phase + 1) / PHASES + 25)
                random_sequence();
        end
        key_in.valid <= 1'b0;

        while (lock_sb.owed_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (lock_sb.errors == 0 && lock_sb.owed_status.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
